[src/ows_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the onewire rom search engine
// no dependencies; used by ows_step and onewire_rom_search_engine_top
package ows_pkg;

    localparam int ROM_BITS_DEF = 64;
    localparam int POS_W        = 6;
    localparam int ROM_OUT_W    = 64;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_START   = 2'd1,
        OP_TRIPLET = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_REQUEST = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_NORESP  = 3'd2,
        KIND_OVER    = 3'd3,
        KIND_CLEARED = 3'd4,
        KIND_IGNORED = 3'd5
    } kind_t;

    typedef struct packed {
        logic [POS_W-1:0] last_disc;
        logic             disc_valid;
        logic [POS_W-1:0] zero_pos;
        logic             zero_seen;
        logic [POS_W-1:0] bit_pos;
        logic             pass_active;
        logic             enum_done;
    } search_state_t;

    typedef struct packed {
        kind_t                kind;
        logic                 req_dir;
        logic [ROM_OUT_W-1:0] found_rom;
        logic                 was_last;
    } search_result_t;

endpackage

[src/ows_step.sv]
`timescale 1ns / 1ps
// one search step: next search state, rom and result for one request
// depends on ows_pkg
module ows_step import ows_pkg::*; #(
    parameter int ROM_BITS = ROM_BITS_DEF
) (
    input  search_state_t       state_i,
    input  logic [ROM_BITS-1:0] rom_i,
    input  logic [1:0]          opcode,
    input  logic                id_bit,
    input  logic                complement_bit,
    input  logic                taken_direction,
    output search_state_t       state_o,
    output logic [ROM_BITS-1:0] rom_o,
    output search_result_t      res_o
);

    localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS - 1);

    logic [POS_W-1:0] next_pos;
    logic [IDX_W-1:0] cur_idx;

    // direction rule, steered by the last discrepancy of the previous pass
    function automatic logic dir_at(input logic [POS_W-1:0] pos);
        logic d;
        if (!state_i.disc_valid) begin
            d = 1'b0;
        end else if (pos < state_i.last_disc) begin
            d = rom_i[pos[IDX_W-1:0]];
        end else begin
            d = (pos == state_i.last_disc);
        end
        return d;
    endfunction

    assign cur_idx  = state_i.bit_pos[IDX_W-1:0];
    assign next_pos = state_i.bit_pos + POS_W'(1);

    always_comb begin
        state_o         = state_i;
        rom_o           = rom_i;
        res_o.kind      = KIND_IGNORED;
        res_o.req_dir   = 1'b0;
        res_o.found_rom = '0;
        res_o.was_last  = 1'b0;
        case (opcode)
            OP_CLEAR: begin
                state_o   = '0;
                rom_o     = '0;
                res_o.kind = KIND_CLEARED;
            end
            OP_START: begin
                if (state_i.enum_done) begin
                    res_o.kind = KIND_OVER;
                end else begin
                    state_o.pass_active = 1'b1;
                    state_o.bit_pos     = '0;
                    state_o.zero_seen   = 1'b0;
                    state_o.zero_pos    = '0;
                    res_o.kind          = KIND_REQUEST;
                    res_o.req_dir       = dir_at('0);
                end
            end
            OP_TRIPLET: begin
                if (state_i.pass_active) begin
                    if (id_bit && complement_bit) begin
                        // nobody answered: abort, keep discrepancy for a retry
                        state_o.pass_active = 1'b0;
                        res_o.kind          = KIND_NORESP;
                    end else begin
                        if (!id_bit && !complement_bit && !taken_direction) begin
                            state_o.zero_pos  = state_i.bit_pos;
                            state_o.zero_seen = 1'b1;
                        end
                        rom_o[cur_idx] = taken_direction;
                        if (state_i.bit_pos >= LAST_POS) begin
                            state_o.pass_active = 1'b0;
                            res_o.kind          = KIND_DONE;
                            res_o.found_rom     = ROM_OUT_W'(rom_o);
                            if (state_o.zero_seen) begin
                                state_o.last_disc  = state_o.zero_pos;
                                state_o.disc_valid = 1'b1;
                            end else begin
                                state_o.enum_done = 1'b1;
                                res_o.was_last    = 1'b1;
                            end
                        end else begin
                            state_o.bit_pos = next_pos;
                            res_o.kind      = KIND_REQUEST;
                            res_o.req_dir   = dir_at(next_pos);
                        end
                    end
                end
            end
            default: begin
                res_o.kind = KIND_IGNORED;
            end
        endcase
    end

endmodule

[src/onewire_rom_search_engine_top.sv]
`timescale 1ns / 1ps
// top level of the onewire rom search engine: request register, search
// state, result register; depends on ows_pkg and ows_step
//
// usage:
//   s_ channel carries requests: s_tuser is the opcode (clear, start pass,
//   triplet result), s_tdata carries the three status bits of a triplet.
//   m_ channel gives exactly one result per request: m_tuser is the result
//   kind, m_tdata holds the direction for the next triplet and the found rom,
//   m_tlast flags the pass that ended the enumeration.
//   an accepted request passes through the request register, then the result
//   register. throughput is one request per cycle while the receiver keeps
//   m_tready high; the search state update is the loop that sets it.
//   each request sees the search state left by the one before it.
//   reset (aresetn low, synchronous) empties both registers and returns the
//   search state and rom to zero, as a clear request does.
//   when the receiver stalls the result holds in m_tdata/m_tuser/m_tlast; one
//   further request may be taken into the request register, then s_tready
//   drops until the result is taken.
module onewire_rom_search_engine_top import ows_pkg::*; #(
    parameter int ROM_BITS = ROM_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] id_bit, [1] complement_bit, [2] taken_direction
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] request_direction, [64:1] found_rom
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast    // was_last
);

    logic                in_valid_reg;
    logic [1:0]          op_reg;
    logic [2:0]          bits_reg;
    logic                out_valid_reg;
    search_result_t      res_reg;
    search_state_t       state_reg;
    logic [ROM_BITS-1:0] rom_reg;

    search_state_t       state_next;
    logic [ROM_BITS-1:0] rom_next;
    search_result_t      res_next;
    logic                out_free;
    logic                advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    ows_step #(
        .ROM_BITS(ROM_BITS)
    ) u_step (
        .state_i         (state_reg),
        .rom_i           (rom_reg),
        .opcode          (op_reg),
        .id_bit          (bits_reg[0]),
        .complement_bit  (bits_reg[1]),
        .taken_direction (bits_reg[2]),
        .state_o         (state_next),
        .rom_o           (rom_next),
        .res_o           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            rom_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                rom_reg       <= rom_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            bits_reg <= s_tdata[2:0];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.found_rom, res_reg.req_dir};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.was_last;

    // enumeration over means no pass can still be running
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.enum_done |-> !state_reg.pass_active)
        else $error("pass active after enumeration end");

    // only a completed pass carries a rom or a last flag
    a_rom_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_DONE) |-> (m_tdata[64:1] == '0 && !m_tlast))
        else $error("rom or last flag outside pass complete");

    // a direction request only while a pass is running
    a_req_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.kind == KIND_REQUEST) |=> state_reg.pass_active)
        else $error("triplet request without active pass");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("result valid after reset");

endmodule
